// ===== rtl/bxas_pkg.sv =====
`default_nettype none

package bxas_pkg;

    localparam int unsigned DataWidth  = 64;
    localparam int unsigned HalfWidth  = 32;
    localparam int unsigned CountBits  = 6;
    localparam int unsigned CountBitsH = 5;

    localparam logic FuncPext = 1'b0;
    localparam logic FuncSarx = 1'b1;

    localparam logic [CountBits-1:0]  CntMask64 = 6'h3f;
    localparam logic [CountBitsH-1:0] CntMask32 = 5'h1f;

    typedef logic [DataWidth-1:0] t_word;

    // input stage contents handed to the execute logic
    typedef struct packed {
        logic  func;
        logic  wide;
        t_word rm_value;
        t_word vex_value;
    } t_op;

    // prefix-xor: each bit becomes the parity of itself and all bits below it
    function automatic t_word prefix_xor(input t_word v);
        t_word p;
        p = v;
        p = p ^ (p << 1);
        p = p ^ (p << 2);
        p = p ^ (p << 4);
        p = p ^ (p << 8);
        p = p ^ (p << 16);
        p = p ^ (p << 32);
        return p;
    endfunction

    // compress the source bits selected by mask into the low end,
    // moving each bit by the powers of two of its zero count below it
    function automatic t_word bit_compress(input t_word src, input t_word mask);
        t_word x;
        t_word m;
        t_word mk;
        t_word mp;
        t_word mv;
        t_word t;
        x  = src & mask;
        m  = mask;
        mk = ~mask << 1;
        for (int i = 0; i < CountBits; i++) begin
            mp = prefix_xor(mk);
            mv = mp & m;
            m  = (m ^ mv) | (mv >> (1 << i));
            t  = x & mv;
            x  = (x ^ t) | (t >> (1 << i));
            mk = mk & ~mp;
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bxas_exec.sv =====
`default_nettype none

module bxas_exec (
    input  var bxas_pkg::t_op   i_op,
    output var bxas_pkg::t_word o_result
);
    import bxas_pkg::*;

    t_word                  src;
    t_word                  mask;
    t_word                  ext_res;
    t_word                  sar_res;
    logic [HalfWidth-1:0]   sar_half;
    logic [CountBits-1:0]   cnt64;
    logic [CountBitsH-1:0]  cnt32;

    // narrow mode clears the upper halves so the compress sees no bits there
    always_comb begin
        if (i_op.wide) begin
            src  = i_op.vex_value;
            mask = i_op.rm_value;
        end else begin
            src  = {{HalfWidth{1'b0}}, i_op.vex_value[HalfWidth-1:0]};
            mask = {{HalfWidth{1'b0}}, i_op.rm_value[HalfWidth-1:0]};
        end
    end

    assign ext_res  = bit_compress(src, mask);

    assign cnt64    = i_op.vex_value[CountBits-1:0] & CntMask64;
    assign cnt32    = i_op.vex_value[CountBitsH-1:0] & CntMask32;
    assign sar_half = HalfWidth'($signed(i_op.rm_value[HalfWidth-1:0]) >>> cnt32);

    always_comb begin
        if (i_op.wide) begin
            sar_res = t_word'($signed(i_op.rm_value) >>> cnt64);
        end else begin
            sar_res = {{HalfWidth{1'b0}}, sar_half};
        end
    end

    always_comb begin
        unique case (i_op.func)
            FuncPext: o_result = ext_res;
            FuncSarx: o_result = sar_res;
            default:  o_result = ext_res;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bit_extract_and_arith_shift_unit.sv =====
// channel   | ports                                          | transfer
// ----------+------------------------------------------------+--------------------------
// command   | start, busy, i_func, i_wide, i_rm_value,       | edge with start && !busy
//           | i_vex_value                                    |
// result    | o_result_valid, o_result                       | edge ending the strobe cycle
//
// one command per cycle outside reset; the result strobes after its transfer has passed
// the operand register, then the result register, with the compress and shift logic between
// busy is high only while reset is held; otherwise commands are always taken
// synchronous active-low reset clears the valid flags; operand data is not reset
// the receiver cannot stall, so no result is ever held back
`default_nettype none

module bit_extract_and_arith_shift_unit (
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    input  var logic                  start,
    output var logic                  busy,
    input  var logic                  i_func,
    input  var logic                  i_wide,
    input  var logic [63:0]           i_rm_value,
    input  var logic [63:0]           i_vex_value,
    output var logic                  o_result_valid,
    output var logic [63:0]           o_result
);
    import bxas_pkg::*;

    logic  r_op_valid;
    logic  n_op_valid;
    t_op   r_op;
    t_op   n_op;
    t_word exec_res;
    logic  r_res_valid;
    t_word r_result;

    assign busy       = ~i_rst_n;
    assign n_op_valid = start & ~busy;
    assign n_op       = '{func: i_func, wide: i_wide, rm_value: i_rm_value,
                          vex_value: i_vex_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_op_valid  <= n_op_valid;
            r_res_valid <= r_op_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_op_valid) begin
            r_op <= n_op;
        end
        if (r_op_valid) begin
            r_result <= exec_res;
        end
    end

    bxas_exec u_exec (
        .i_op     (r_op),
        .o_result (exec_res)
    );

    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

endmodule

`default_nettype wire

// ===== rtl/bxas_checker.sv =====
`default_nettype none

module bxas_checker (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        start,
    input  var logic        busy,
    input  var logic        i_func,
    input  var logic        i_wide,
    input  var logic [63:0] i_rm_value,
    input  var logic [63:0] i_vex_value,
    input  var logic        o_result_valid,
    input  var logic [63:0] o_result
);
    import bxas_pkg::*;

    logic xfer;
    assign xfer = start & ~busy;

    // every transfer gives a result strobe unless reset intervenes
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer ##1 i_rst_n) |=> o_result_valid)
        else $error("result strobe missing after command transfer");

    // no result without an earlier command transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(xfer, 2))
        else $error("result strobe without command");

    // narrow operations zero the upper half
    a_narrow_zext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(xfer && !i_wide, 2)) |-> (o_result[63:32] == 32'h0))
        else $error("narrow result not zero-extended");

    // wide shift by zero passes the value through
    a_sar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(xfer && (i_func == FuncSarx) && i_wide
                                 && (i_vex_value[5:0] == 6'h0), 2))
        |-> (o_result == $past(i_rm_value, 2)))
        else $error("shift by zero altered the value");

    // wide extract under a full mask returns the source
    a_pext_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(xfer && (i_func == FuncPext) && i_wide
                                 && (i_rm_value == 64'hffff_ffff_ffff_ffff), 2))
        |-> (o_result == $past(i_vex_value, 2)))
        else $error("extract with full mask altered the source");

endmodule

bind bit_extract_and_arith_shift_unit bxas_checker u_bxas_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_func         (i_func),
    .i_wide         (i_wide),
    .i_rm_value     (i_rm_value),
    .i_vex_value    (i_vex_value),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire

// ===== sim/tb_bit_extract_and_arith_shift_unit.sv =====
`default_nettype none

module tb_bit_extract_and_arith_shift_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import bxas_pkg::*;

    localparam int unsigned RandomOps   = 1750;
    localparam int unsigned MaxGap      = 18;
    localparam int unsigned BurstLen    = 64;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned NumRows     = 21;

    localparam t_word AllOnes = 64'hffff_ffff_ffff_ffff;
    localparam t_word SignBit = 64'h8000_0000_0000_0000;
    localparam t_word LowHalf = 64'h0000_0000_ffff_ffff;

    typedef struct packed {
        logic  func;
        logic  wide;
        t_word rm;
        t_word vex;
        logic  typed;
        t_word value;
    } t_row;

    // rows with typed = 0 are checked against the predictor
    t_row directed_rows [NumRows] = '{
        '{FuncPext, 1'b1, 64'h0, AllOnes, 1'b1, 64'h0},
        '{FuncPext, 1'b1, AllOnes, 64'hdead_beef_0123_4567, 1'b1, 64'hdead_beef_0123_4567},
        '{FuncPext, 1'b0, AllOnes, AllOnes, 1'b1, LowHalf},
        '{FuncPext, 1'b0, 64'hffff_ffff_0000_0000, AllOnes, 1'b1, 64'h0},
        '{FuncPext, 1'b1, SignBit, SignBit, 1'b1, 64'h1},
        '{FuncPext, 1'b1, 64'haaaa_aaaa_aaaa_aaaa, AllOnes, 1'b1, LowHalf},
        '{FuncPext, 1'b0, 64'h0000_0000_8000_0000, 64'h0000_0000_8000_0000, 1'b1, 64'h1},
        '{FuncPext, 1'b1, 64'hf0f0_f0f0_f0f0_f0f0, 64'h1234_5678_9abc_def0, 1'b0, 64'h0},
        '{FuncPext, 1'b0, 64'h1234_5678_0f0f_0f0f, 64'hffff_0000_a5a5_a5a5, 1'b0, 64'h0},
        '{FuncPext, 1'b0, 64'hffff_ffff_0000_0001, 64'h1, 1'b1, 64'h1},
        '{FuncSarx, 1'b1, SignBit, 64'd63, 1'b1, AllOnes},
        '{FuncSarx, 1'b1, SignBit, 64'h40, 1'b1, SignBit},
        '{FuncSarx, 1'b1, 64'h7fff_ffff_ffff_ffff, 64'd63, 1'b1, 64'h0},
        '{FuncSarx, 1'b1, AllOnes, AllOnes, 1'b1, AllOnes},
        '{FuncSarx, 1'b1, 64'h0, 64'h0, 1'b1, 64'h0},
        '{FuncSarx, 1'b0, 64'hffff_ffff_8000_0000, 64'd31, 1'b1, LowHalf},
        '{FuncSarx, 1'b0, 64'h0000_0000_8000_0000, 64'h20, 1'b1, 64'h0000_0000_8000_0000},
        '{FuncSarx, 1'b0, 64'hffff_ffff_7fff_ffff, 64'hffff_ffff_ffff_ffe1, 1'b1,
          64'h0000_0000_3fff_ffff},
        '{FuncSarx, 1'b0, LowHalf, 64'h0, 1'b1, LowHalf},
        '{FuncSarx, 1'b1, 64'hc000_0000_1234_5678, 64'hffff_ffff_ffff_ff04, 1'b0, 64'h0},
        '{FuncSarx, 1'b0, 64'h1234_5678_9abc_def0, 64'h47, 1'b0, 64'h0}
    };

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  start       = 1'b0;
    logic  i_func      = FuncPext;
    logic  i_wide      = 1'b0;
    t_word i_rm_value  = '0;
    t_word i_vex_value = '0;
    logic  busy;
    logic  o_result_valid;
    t_word o_result;

    // a typed expectation rides along with the command fields
    logic  cmd_typed       = 1'b0;
    t_word cmd_typed_value = '0;

    t_word       expected_results [$];
    t_word       want;
    int unsigned err_count     = 0;
    int unsigned cycle_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned extract_count = 0;
    int unsigned shift_count   = 0;
    int unsigned narrow_count  = 0;
    logic        burst_mode    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bit_extract_and_arith_shift_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_wide        (i_wide),
        .i_rm_value    (i_rm_value),
        .i_vex_value   (i_vex_value),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    function automatic t_word compute_result(input logic func, input logic wide,
                                             input t_word rm, input t_word vex);
        t_word             mask;
        t_word             acc;
        int unsigned       pos;
        logic signed [63:0] v64;
        logic signed [31:0] v32;
        acc = '0;
        if (func == FuncPext) begin
            mask = wide ? rm : {32'h0, rm[31:0]};
            pos  = 0;
            for (int i = 0; i < 64; i++) begin
                if (mask[i]) begin
                    acc[pos] = vex[i];
                    pos++;
                end
            end
        end else if (wide) begin
            v64 = rm;
            acc = v64 >>> vex[5:0];
        end else begin
            v32 = rm[31:0];
            acc = {32'h0, v32 >>> vex[4:0]};
        end
        return acc;
    endfunction

    // zero, all ones, one-hot, sparse, dense and plain random operands
    function automatic t_word rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return AllOnes;
            2: return t_word'(1) << $urandom_range(0, 63);
            3: return {$urandom, $urandom} & {$urandom, $urandom};
            4: return {$urandom, $urandom} | {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // start stays high across back-to-back transfers
    task automatic send_op(input logic func, input logic wide, input t_word rm,
                           input t_word vex, input logic typed, input t_word value);
        start           <= 1'b1;
        i_func          <= func;
        i_wide          <= wide;
        i_rm_value      <= rm;
        i_vex_value     <= vex;
        cmd_typed       <= typed;
        cmd_typed_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_gap();
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, MaxGap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid === 1'b1) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing outstanding", o_result));
                end else begin
                    want = expected_results.pop_front();
                    if (o_result !== want)
                        report_mismatch($sformatf("result %h, expected %h", o_result, want));
                end
            end else if (o_result_valid !== 1'b0) begin
                report_mismatch("result strobe unknown");
            end
            if (start && busy === 1'b0) begin
                expected_results.push_back(cmd_typed ? cmd_typed_value :
                    compute_result(i_func, i_wide, i_rm_value, i_vex_value));
                if (i_func == FuncPext) extract_count++;
                else shift_count++;
                if (!i_wide) narrow_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("bit_extract_and_arith_shift_unit test failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NumRows; r++) begin
            send_op(directed_rows[r].func, directed_rows[r].wide, directed_rows[r].rm,
                    directed_rows[r].vex, directed_rows[r].typed, directed_rows[r].value);
            idle_gap();
        end

        for (int n = 0; n < RandomOps; n++) begin
            // randomly pick back-to-back or gapped for each stretch of commands
            if (n % BurstLen == 0) burst_mode = ($urandom_range(0, 3) == 0);
            send_op(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    rand_word(), rand_word(), 1'b0, '0);
            if (n + 1 < RandomOps) idle_gap();
        end
        start <= 1'b0;

        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);

        $display("covered %0d extract and %0d shift commands, %0d of them 32-bit",
                 extract_count, shift_count, narrow_count);
        $display("checked %0d results, %0d mismatches", results_seen, err_count);
        if (err_count == 0) begin
            $display("bit_extract_and_arith_shift_unit test passed");
        end else begin
            $display("bit_extract_and_arith_shift_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
